>>> rtl/core/ecv_pkg.sv
package ecv_pkg;

    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
    localparam logic signed [31:0] SC1 = 32'sd1686629713;
    localparam logic signed [31:0] SC3 = -32'sd693598668;
    localparam logic signed [31:0] SC5 = 32'sd85569306;
    localparam logic signed [31:0] SC7 = -32'sd5026995;
    localparam logic signed [31:0] SC9 = 32'sd172272;

    // Rotation order codes of the configuration register.
    localparam logic [2:0] ORD_XYZ = 3'd0;
    localparam logic [2:0] ORD_YXZ = 3'd1;
    localparam logic [2:0] ORD_XZY = 3'd2;
    localparam logic [2:0] ORD_YZX = 3'd3;
    localparam logic [2:0] ORD_ZYX = 3'd4;
    localparam logic [2:0] ORD_ZXY = 3'd5;

    localparam logic [1:0] LAST_ROW = 2'd3;

    typedef enum logic [1:0] {MAT_X, MAT_Y, MAT_Z, MAT_I} mat_sel_t;

    typedef struct packed {
        mat_sel_t first;
        mat_sel_t second;
        mat_sel_t third;
    } order_t;

    function automatic order_t order_decode(input logic [2:0] ord);
        order_t o;
        unique case (ord)
            ORD_XYZ: o = '{MAT_X, MAT_Y, MAT_Z};
            ORD_YXZ: o = '{MAT_Y, MAT_X, MAT_Z};
            ORD_XZY: o = '{MAT_X, MAT_Z, MAT_Y};
            ORD_YZX: o = '{MAT_Y, MAT_Z, MAT_X};
            ORD_ZYX: o = '{MAT_Z, MAT_Y, MAT_X};
            ORD_ZXY: o = '{MAT_Z, MAT_X, MAT_Y};
            default: o = '{MAT_I, MAT_I, MAT_I};
        endcase
        return o;
    endfunction

    // Q30 product, floored.
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] pr;
        pr = a * b;
        return pr[61:30];
    endfunction

endpackage

>>> rtl/core/ecv_if.sv
interface ecv_in_if #(
    parameter int CW = 32,
    parameter int AW = 16
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic [AW-1:0]        angle_x;
    logic [AW-1:0]        angle_y;
    logic [AW-1:0]        angle_z;

    modport source (output valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                    input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                  output ready);
endinterface

interface ecv_out_if #(
    parameter int CW = 32
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           row_index;
    logic signed [CW-1:0] col0;
    logic signed [CW-1:0] col1;
    logic signed [CW-1:0] col2;
    logic signed [CW-1:0] col3;
    logic                 last_row;

    modport source (output valid, row_index, col0, col1, col2, col3, last_row,
                    input ready);
    modport sink (input valid, row_index, col0, col1, col2, col3, last_row,
                  output ready);
endinterface

>>> rtl/core/ecv_front.sv
module ecv_front
    import ecv_pkg::*;
#(
    parameter int CW = 32,
    parameter int AW = 16,
    parameter int PW = 3 * (CW + 1) + 102
)(
    ecv_in_if.sink        in_ch,
    output logic          push_valid,
    output logic [PW-1:0] push_data,
    input  logic          push_ready
);

    localparam int NW  = CW + 1;
    localparam int XSH = 32 - AW;

    logic [AW-1:0]        ang [3];
    logic signed [CW-1:0] pos [3];

    always_comb
    begin
        logic [AW-1:0] a;
        ang[0] = in_ch.angle_x;
        ang[1] = in_ch.angle_y;
        ang[2] = in_ch.angle_z;
        pos[0] = in_ch.pos_x;
        pos[1] = in_ch.pos_y;
        pos[2] = in_ch.pos_z;
        push_data = '0;
        for (int i = 0; i < 3; i++)
        begin
            // The inverse rotation uses the negated angle: split it into
            // quadrant and a Q30 fraction of a quarter turn.
            a = AW'(0) - ang[i];
            push_data[(2 - i) * 32 +: 32] = {2'b00, a[AW-3:0], {XSH{1'b0}}};
            push_data[96 + (2 - i) * 2 +: 2] = a[AW-1:AW-2];
            push_data[102 + (2 - i) * NW +: NW] = NW'(0) - {pos[i][CW-1], pos[i]};
        end
    end

    assign push_valid  = in_ch.valid;
    assign in_ch.ready = push_ready;

endmodule

>>> rtl/core/ecv_queue.sv
module ecv_queue #(
    parameter int W = 8
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    input  logic [W-1:0] push_data,
    output logic         push_ready,
    output logic         pop_valid,
    output logic [W-1:0] pop_data,
    input  logic         pop_ready
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         push;
    logic         pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> rtl/core/ecv_back.sv
module ecv_back
    import ecv_pkg::*;
#(
    parameter int CW = 32,
    parameter int F  = 16,
    parameter int PW = 3 * (CW + 1) + 102
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [2:0]    order,
    input  logic          pop_valid,
    input  logic [PW-1:0] pop_data,
    output logic          pop_ready,
    ecv_out_if.source     out_ch
);

    localparam int EW   = F + 2;
    localparam int NW   = CW + 1;
    localparam int PRW  = NW + EW;
    localparam int SUMW = PRW + 2;
    localparam int RSH  = 30 - F;
    localparam int NST  = 12;

    localparam logic signed [32:0] RND =
        (RSH > 0) ? (33'sd1 <<< ((RSH > 0) ? RSH - 1 : 0)) : 33'sd0;
    localparam logic signed [EW-1:0] ONE_F = EW'(1) <<< F;
    localparam logic signed [2*EW+1:0] HALF_M = (2*EW+2)'(1) <<< (F - 1);
    localparam logic signed [SUMW-1:0] HALF_S = SUMW'(1) <<< (F - 1);
    localparam logic signed [SUMW-1:0] SAT_MAX = (SUMW'(1) <<< (CW - 1)) - SUMW'(1);
    localparam logic signed [SUMW-1:0] SAT_MIN = -SAT_MAX - SUMW'(1);
    localparam logic [CW-1:0] COL3_ONE =
        (F >= CW - 1) ? {1'b0, {(CW-1){1'b1}}} : (CW'(1) << F);

    function automatic logic [CW-1:0] sat_cw(input logic signed [SUMW-1:0] v);
        if (v > SAT_MAX)
            return SAT_MAX[CW-1:0];
        if (v < SAT_MIN)
            return SAT_MIN[CW-1:0];
        return v[CW-1:0];
    endfunction

    function automatic logic signed [EW-1:0] to_frac(input logic signed [31:0] v);
        logic signed [32:0] t;
        t = {v[31], v} + RND;
        t = t >>> RSH;
        return t[EW-1:0];
    endfunction

    function automatic logic signed [31:0] clamp_q30(input logic signed [31:0] v);
        if (v < 0)
            return 32'sd0;
        if (v > ONE_Q30)
            return ONE_Q30;
        return v;
    endfunction

    function automatic logic signed [EW-1:0] dot3(
        input logic signed [EW-1:0] a0, input logic signed [EW-1:0] a1,
        input logic signed [EW-1:0] a2, input logic signed [EW-1:0] b0,
        input logic signed [EW-1:0] b1, input logic signed [EW-1:0] b2);
        logic signed [2*EW+1:0] s;
        s = a0 * b0 + a1 * b1 + a2 * b2 + HALF_M;
        s = s >>> F;
        return s[EW-1:0];
    endfunction

    logic                  en;
    logic [NST-1:0]        vld_reg;
    logic [1:0]            q_reg   [7][3];
    logic signed [NW-1:0]  np_reg  [11][3];
    logic signed [31:0]    xin0_reg [6];
    logic signed [31:0]    xin1_reg [6];
    logic signed [31:0]    xin2_reg [6];
    logic signed [31:0]    xin3_reg [6];
    logic signed [31:0]    xin4_reg [6];
    logic signed [31:0]    xin5_reg [6];
    logic signed [31:0]    x2_1_reg [6];
    logic signed [31:0]    x2_2_reg [6];
    logic signed [31:0]    x2_3_reg [6];
    logic signed [31:0]    x2_4_reg [6];
    logic signed [31:0]    p2_reg [6];
    logic signed [31:0]    p3_reg [6];
    logic signed [31:0]    p4_reg [6];
    logic signed [31:0]    p5_reg [6];
    logic signed [31:0]    p6_reg [6];
    logic signed [EW-1:0]  sn7_reg [3];
    logic signed [EW-1:0]  cs7_reg [3];
    logic signed [EW-1:0]  sn7_next [3];
    logic signed [EW-1:0]  cs7_next [3];
    logic signed [EW-1:0]  ma_reg [3][3];
    logic signed [EW-1:0]  mb_reg [3][3];
    logic signed [EW-1:0]  mc_reg [3][3];
    logic signed [EW-1:0]  mc9_reg [3][3];
    logic signed [EW-1:0]  ma_next [3][3];
    logic signed [EW-1:0]  mb_next [3][3];
    logic signed [EW-1:0]  mc_next [3][3];
    logic signed [EW-1:0]  m_all [4][3][3];
    logic signed [EW-1:0]  tmp_reg [3][3];
    logic signed [EW-1:0]  rot10_reg [3][3];
    logic signed [EW-1:0]  rot11_reg [3][3];
    logic signed [PRW-1:0] prod_reg [3][3];
    logic [CW-1:0]         row3_next [3];
    logic [CW-1:0]         mat_reg [4][3];
    logic                  out_valid_reg;
    logic [1:0]            row_reg;
    logic                  load;
    order_t                ord;

    // The whole pipeline moves in step with the row emitter; a new matrix is
    // taken once the last row of the previous one is transferred.
    assign en        = !out_valid_reg || (out_ch.ready && row_reg == LAST_ROW);
    assign pop_ready = en;
    assign load      = en && vld_reg[NST-1];
    assign ord       = order_decode(order);

    always_comb
    begin
        logic signed [31:0] s0;
        logic signed [31:0] c0;
        logic signed [31:0] sv;
        logic signed [31:0] cv;
        for (int a = 0; a < 3; a++)
        begin
            s0 = clamp_q30(p6_reg[2*a]);
            c0 = clamp_q30(p6_reg[2*a+1]);
            case (q_reg[6][a])
                2'd0:    begin sv = s0;  cv = c0;  end
                2'd1:    begin sv = c0;  cv = -s0; end
                2'd2:    begin sv = -s0; cv = -c0; end
                default: begin sv = -c0; cv = s0;  end
            endcase
            sn7_next[a] = to_frac(sv);
            cs7_next[a] = to_frac(cv);
        end
    end

    always_comb
    begin
        for (int m = 0; m < 4; m++)
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    m_all[m][i][j] = '0;
        m_all[MAT_X][0][0] = ONE_F;
        m_all[MAT_X][1][1] = cs7_reg[0];
        m_all[MAT_X][1][2] = sn7_reg[0];
        m_all[MAT_X][2][1] = -sn7_reg[0];
        m_all[MAT_X][2][2] = cs7_reg[0];
        m_all[MAT_Y][0][0] = cs7_reg[1];
        m_all[MAT_Y][0][2] = -sn7_reg[1];
        m_all[MAT_Y][1][1] = ONE_F;
        m_all[MAT_Y][2][0] = sn7_reg[1];
        m_all[MAT_Y][2][2] = cs7_reg[1];
        m_all[MAT_Z][0][0] = cs7_reg[2];
        m_all[MAT_Z][0][1] = sn7_reg[2];
        m_all[MAT_Z][1][0] = -sn7_reg[2];
        m_all[MAT_Z][1][1] = cs7_reg[2];
        m_all[MAT_Z][2][2] = ONE_F;
        for (int i = 0; i < 3; i++)
            m_all[MAT_I][i][i] = ONE_F;
        ma_next = m_all[ord.first];
        mb_next = m_all[ord.second];
        mc_next = m_all[ord.third];
    end

    always_comb
    begin
        logic signed [SUMW-1:0] sum;
        for (int j = 0; j < 3; j++)
        begin
            sum = SUMW'(prod_reg[0][j]) + SUMW'(prod_reg[1][j]) + SUMW'(prod_reg[2][j])
                  + HALF_S;
            sum = sum >>> F;
            row3_next[j] = sat_cw(sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                q_reg[0][a]  <= pop_data[96 + (2 - a) * 2 +: 2];
                np_reg[0][a] <= pop_data[102 + (2 - a) * NW +: NW];
                xin0_reg[2*a]   <= pop_data[(2 - a) * 32 +: 32];
                xin0_reg[2*a+1] <= ONE_Q30 - $signed(pop_data[(2 - a) * 32 +: 32]);
            end
            for (int s = 1; s < 7; s++)
                q_reg[s] <= q_reg[s-1];
            for (int s = 1; s < 11; s++)
                np_reg[s] <= np_reg[s-1];
            for (int l = 0; l < 6; l++)
            begin
                x2_1_reg[l] <= mulq(xin0_reg[l], xin0_reg[l]);
                xin1_reg[l] <= xin0_reg[l];
                p2_reg[l]   <= SC7 + mulq(SC9, x2_1_reg[l]);
                x2_2_reg[l] <= x2_1_reg[l];
                xin2_reg[l] <= xin1_reg[l];
                p3_reg[l]   <= SC5 + mulq(p2_reg[l], x2_2_reg[l]);
                x2_3_reg[l] <= x2_2_reg[l];
                xin3_reg[l] <= xin2_reg[l];
                p4_reg[l]   <= SC3 + mulq(p3_reg[l], x2_3_reg[l]);
                x2_4_reg[l] <= x2_3_reg[l];
                xin4_reg[l] <= xin3_reg[l];
                p5_reg[l]   <= SC1 + mulq(p4_reg[l], x2_4_reg[l]);
                xin5_reg[l] <= xin4_reg[l];
                p6_reg[l]   <= mulq(p5_reg[l], xin5_reg[l]);
            end
            sn7_reg <= sn7_next;
            cs7_reg <= cs7_next;
            ma_reg  <= ma_next;
            mb_reg  <= mb_next;
            mc_reg  <= mc_next;
            mc9_reg <= mc_reg;
            rot11_reg <= rot10_reg;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    tmp_reg[i][j] <= dot3(ma_reg[i][0], ma_reg[i][1], ma_reg[i][2],
                                          mb_reg[0][j], mb_reg[1][j], mb_reg[2][j]);
                    rot10_reg[i][j] <= dot3(tmp_reg[i][0], tmp_reg[i][1], tmp_reg[i][2],
                                            mc9_reg[0][j], mc9_reg[1][j], mc9_reg[2][j]);
                    // Indexed [k][j]: row k of the rotation scaled by -p_k.
                    prod_reg[i][j] <= np_reg[10][i] * rot10_reg[i][j];
                end
        end
        if (load)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    mat_reg[i][j] <= sat_cw(SUMW'(rot11_reg[i][j]));
            mat_reg[3] <= row3_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            row_reg       <= 2'd0;
        end
        else
        begin
            if (en)
            begin
                vld_reg       <= {vld_reg[NST-2:0], pop_valid};
                out_valid_reg <= vld_reg[NST-1];
                row_reg       <= 2'd0;
            end
            else if (out_ch.ready)
                row_reg <= row_reg + 2'd1;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.row_index = row_reg;
    assign out_ch.col0      = mat_reg[row_reg][0];
    assign out_ch.col1      = mat_reg[row_reg][1];
    assign out_ch.col2      = mat_reg[row_reg][2];
    assign out_ch.col3      = (row_reg == LAST_ROW) ? COL3_ONE : '0;
    assign out_ch.last_row  = (row_reg == LAST_ROW);

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NST-1] && !en |=> vld_reg[NST-1])
        else $error("pipeline item lost while the emitter was busy");
    a_row_steps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ch.ready && row_reg != LAST_ROW
        |=> out_valid_reg && row_reg == $past(row_reg) + 2'd1)
        else $error("row sequence broken after a transfer");
    a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && pop_ready |=> vld_reg[0])
        else $error("queue item did not enter the pipeline");
`endif

endmodule

>>> rtl/core/euler_camera_view_matrix.sv
// Euler-angle camera view matrix.
// in_ch carries a camera position (signed Q16.16) and three binary angles;
// out_ch returns the 4x4 view matrix as four transfers, rows 0 to 3 in order,
// with last_row set on row 3. The row-3 entries carry the inverse translation.
// cfg_we / cfg_wdata write the rotation order; write it only while the block
// is idle. Codes 6 and 7 give the identity rotation.
// An accepted item is written into the queue at the same edge, crosses a
// twelve-stage pipeline (sine polynomial, two matrix products, translation)
// and row 0 then appears on out_ch. The row emitter sends one row per cycle
// while out_ch.ready is high; the pipeline advances each time the emitter
// takes a matrix.
// A two-entry queue lets inputs keep arriving while the output is stalled;
// when the receiver holds ready low the current row stays on out_ch and the
// pipeline stops until row 3 is transferred.
// Reset clears all valid flags, empties the queue and sets the order to XYZ.
module euler_camera_view_matrix
    import ecv_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int ANGLE_WIDTH = 16
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    ecv_in_if.sink     in_ch,
    ecv_out_if.source  out_ch
);

    localparam int PW = 3 * (COORD_WIDTH + 1) + 102;

    logic [2:0]    order_reg;
    logic          push_valid;
    logic [PW-1:0] push_data;
    logic          push_ready;
    logic          pop_valid;
    logic [PW-1:0] pop_data;
    logic          pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= ORD_XYZ;
        else if (cfg_we)
            order_reg <= cfg_wdata;
    end

    ecv_front #(
        .CW (COORD_WIDTH),
        .AW (ANGLE_WIDTH),
        .PW (PW)
    ) u_front (
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    ecv_queue #(
        .W (PW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    ecv_back #(
        .CW (COORD_WIDTH),
        .F  (FRAC_BITS),
        .PW (PW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .order     (order_reg),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .out_ch    (out_ch)
    );

endmodule
